// ===== design/pmj_pkg.sv =====
// Package for the pyramid map and Jacobian unit: widths, payload and stage
// types, and the rounding and saturation helpers. No dependencies.
package pmj_pkg;

    localparam int COORD_WIDTH = 32;
    // Stored node coordinates and results keep this many bits (16 to 32).
    localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);

    localparam int FRAC_REF     = 30;
    localparam int NODE_COUNT   = 5;
    localparam int AXIS_COUNT   = 3;
    localparam int SET_COUNT    = 4;      // point weights, d/dx, d/dy, d/dz
    localparam int STORE_DEPTH  = NODE_COUNT * AXIS_COUNT;
    localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

    localparam int W_W    = 34;           // w = 1 - z in Q4.30
    localparam int NUM_W  = 64;           // divider numerator
    localparam int DEN_W  = 34;           // divider denominator
    localparam int QUOT_W = 36;           // quotient bits kept before clamping
    localparam int QS_W   = QUOT_W + 1;   // signed clamped quotient
    localparam int DIV_LAT = QUOT_W + 4;  // register stages in one divider
    localparam int SUM_W  = 40;           // weight numerator before quarter
    localparam int PROD_W = 32 + CW;
    localparam int ACC_W  = PROD_W + 3;
    localparam int PART_COUNT = 3;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } pmj_op_t;

    typedef struct packed {
        logic               op;
        logic [2:0]         node_index;
        logic [1:0]         axis;
        logic signed [31:0] node_value;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_z;
    } pmj_in_t;

    typedef struct packed {
        logic signed [31:0] phys_x;
        logic signed [31:0] phys_y;
        logic signed [31:0] phys_z;
        logic signed [31:0] jac_xx;
        logic signed [31:0] jac_xy;
        logic signed [31:0] jac_xz;
        logic signed [31:0] jac_yx;
        logic signed [31:0] jac_yy;
        logic signed [31:0] jac_yz;
        logic signed [31:0] jac_zx;
        logic signed [31:0] jac_zy;
        logic signed [31:0] jac_zz;
    } pmj_out_t;

    typedef struct packed {
        logic       valid;
        logic       op;
        logic [2:0] node_index;
        logic [1:0] axis;
    } pmj_ctl_t;

    // Carried alongside the first divider rank.
    typedef struct packed {
        pmj_ctl_t                 ctl;
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic signed [W_W-1:0]    w;
        logic signed [QS_W-1:0]   qs;
        logic                     wz;
    } pmj_sb1_t;

    // Carried alongside the second divider.
    typedef struct packed {
        pmj_ctl_t                 ctl;
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic signed [W_W-1:0]    w;
        logic                     wz;
        logic signed [QS_W-1:0]   q;
        logic signed [QS_W-1:0]   a;
        logic signed [QS_W-1:0]   b;
    } pmj_sb2_t;

    typedef struct packed {
        logic [SET_COUNT-1:0][NODE_COUNT-1:0][31:0] w;
    } pmj_wt_t;

    // floor((n + 2) / 4), saturated to 32 bits
    function automatic logic signed [31:0] quarter(input logic signed [SUM_W-1:0] n);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        t  = (n + SUM_W'(2)) >>> 2;
        hi = (SUM_W'(1) <<< 31) - SUM_W'(1);
        lo = -(SUM_W'(1) <<< 31);
        if (t > hi)
            return 32'sh7FFF_FFFF;
        else if (t < lo)
            return 32'sh8000_0000;
        else
            return t[31:0];
    endfunction

    function automatic logic signed [31:0] sat_q32(input logic signed [QS_W-1:0] v);
        logic signed [QS_W-1:0] hi;
        logic signed [QS_W-1:0] lo;
        hi = (QS_W'(1) <<< 31) - QS_W'(1);
        lo = -(QS_W'(1) <<< 31);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Saturate to CW bits, sign-extended to 32.
    function automatic logic signed [31:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (CW - 1)) - ACC_W'(1);
        lo = -(ACC_W'(1) <<< (CW - 1));
        if (v > hi)
            return 32'(hi);
        else if (v < lo)
            return 32'(lo);
        else
            return v[31:0];
    endfunction

endpackage

// ===== design/pmj_div.sv =====
// Pipelined rounding divider, one quotient bit per stage, quotient clamped.
// Depends on pmj_pkg.
module pmj_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [pmj_pkg::NUM_W-1:0] num,
    input  logic signed [pmj_pkg::DEN_W-1:0] den,
    output logic signed [pmj_pkg::QS_W-1:0]  quot
);

    logic [pmj_pkg::NUM_W-1:0]  an_reg;
    logic [pmj_pkg::DEN_W-1:0]  ad_reg;
    logic                       neg0_reg;
    logic [pmj_pkg::NUM_W-1:0]  nn_reg;
    logic [pmj_pkg::DEN_W-1:0]  dd_reg;
    logic                       neg1_reg;

    logic [pmj_pkg::DEN_W-1:0]  rem_reg [pmj_pkg::QUOT_W+1];
    logic [pmj_pkg::QUOT_W-1:0] nq_reg  [pmj_pkg::QUOT_W+1];
    logic [pmj_pkg::DEN_W-1:0]  dv_reg  [pmj_pkg::QUOT_W+1];
    logic                       neg_reg [pmj_pkg::QUOT_W+1];
    logic                       ovf_reg [pmj_pkg::QUOT_W+1];

    logic [pmj_pkg::DEN_W:0]    t_w      [pmj_pkg::QUOT_W];
    logic                       ge_w     [pmj_pkg::QUOT_W];
    logic [pmj_pkg::DEN_W-1:0]  rem_next [pmj_pkg::QUOT_W];
    logic [pmj_pkg::QUOT_W-1:0] nq_next  [pmj_pkg::QUOT_W];

    logic [pmj_pkg::QUOT_W-1:0] mag_w;
    logic signed [pmj_pkg::QS_W-1:0] quot_reg;

    always_comb
    begin
        for (int k = 0; k < pmj_pkg::QUOT_W; k++)
        begin
            t_w[k]  = {rem_reg[k], nq_reg[k][pmj_pkg::QUOT_W-1]};
            ge_w[k] = t_w[k] >= {1'b0, dv_reg[k]};
            rem_next[k] = ge_w[k] ? pmj_pkg::DEN_W'(t_w[k] - {1'b0, dv_reg[k]})
                                  : t_w[k][pmj_pkg::DEN_W-1:0];
            nq_next[k]  = {nq_reg[k][pmj_pkg::QUOT_W-2:0], ge_w[k]};
        end
        mag_w = ovf_reg[pmj_pkg::QUOT_W] ? '1 : nq_reg[pmj_pkg::QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes and sign
            an_reg   <= num[pmj_pkg::NUM_W-1] ? pmj_pkg::NUM_W'(-num) : pmj_pkg::NUM_W'(num);
            ad_reg   <= den[pmj_pkg::DEN_W-1] ? pmj_pkg::DEN_W'(-den) : pmj_pkg::DEN_W'(den);
            neg0_reg <= num[pmj_pkg::NUM_W-1] ^ den[pmj_pkg::DEN_W-1];
            // round to nearest: (2|n| + |d|) / (2|d|)
            nn_reg   <= (an_reg << 1) + pmj_pkg::NUM_W'(ad_reg);
            dd_reg   <= ad_reg << 1;
            neg1_reg <= neg0_reg;
            // high part must stay below the divisor, else clamp
            rem_reg[0] <= pmj_pkg::DEN_W'(nn_reg[pmj_pkg::NUM_W-1:pmj_pkg::QUOT_W]);
            nq_reg[0]  <= nn_reg[pmj_pkg::QUOT_W-1:0];
            dv_reg[0]  <= dd_reg;
            neg_reg[0] <= neg1_reg;
            ovf_reg[0] <= pmj_pkg::DEN_W'(nn_reg[pmj_pkg::NUM_W-1:pmj_pkg::QUOT_W]) >= dd_reg;
            for (int k = 0; k < pmj_pkg::QUOT_W; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                nq_reg[k+1]  <= nq_next[k];
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
            quot_reg <= neg_reg[pmj_pkg::QUOT_W] ? -$signed({1'b0, mag_w})
                                                 : $signed({1'b0, mag_w});
        end
    end

    assign quot = quot_reg;

endmodule

// ===== design/pmj_weights.sv =====
// Shape function weight stage: point weights and the three derivative sets.
// Depends on pmj_pkg.
module pmj_weights (
    input  logic                            clk,
    input  logic                            en,
    input  pmj_pkg::pmj_sb2_t               sb,
    input  logic signed [pmj_pkg::QS_W-1:0] d2_quot,
    output pmj_pkg::pmj_wt_t                wt
);

    logic signed [pmj_pkg::SUM_W-1:0] one_w;
    logic signed [pmj_pkg::SUM_W-1:0] xs_w;
    logic signed [pmj_pkg::SUM_W-1:0] ys_w;
    logic signed [pmj_pkg::SUM_W-1:0] ws_w;
    logic signed [pmj_pkg::SUM_W-1:0] qs_w;
    logic signed [pmj_pkg::SUM_W-1:0] as_w;
    logic signed [pmj_pkg::SUM_W-1:0] bs_w;
    logic signed [pmj_pkg::SUM_W-1:0] ds_w;
    logic signed [pmj_pkg::W_W-1:0]   z_w;
    pmj_pkg::pmj_wt_t                 wt_next;
    pmj_pkg::pmj_wt_t                 wt_reg;

    always_comb
    begin
        one_w = pmj_pkg::SUM_W'(1) <<< pmj_pkg::FRAC_REF;
        xs_w  = pmj_pkg::SUM_W'(sb.x);
        ys_w  = pmj_pkg::SUM_W'(sb.y);
        ws_w  = pmj_pkg::SUM_W'(sb.w);
        qs_w  = pmj_pkg::SUM_W'(sb.q);
        as_w  = pmj_pkg::SUM_W'(sb.a);
        bs_w  = pmj_pkg::SUM_W'(sb.b);
        // top plane: the d/dz term divided by w drops out
        ds_w  = sb.wz ? '0 : pmj_pkg::SUM_W'(d2_quot);
        z_w   = (pmj_pkg::W_W'(1) <<< pmj_pkg::FRAC_REF) - sb.w;

        wt_next.w[0][0] = z_w[31:0];
        wt_next.w[0][1] = pmj_pkg::quarter(ws_w - xs_w - ys_w + qs_w);
        wt_next.w[0][2] = pmj_pkg::quarter(ws_w + xs_w - ys_w - qs_w);
        wt_next.w[0][3] = pmj_pkg::quarter(ws_w - xs_w + ys_w - qs_w);
        wt_next.w[0][4] = pmj_pkg::quarter(ws_w + xs_w + ys_w + qs_w);

        wt_next.w[1][0] = '0;
        wt_next.w[1][1] = pmj_pkg::quarter(-one_w + as_w);
        wt_next.w[1][2] = pmj_pkg::quarter(one_w - as_w);
        wt_next.w[1][3] = pmj_pkg::quarter(-one_w - as_w);
        wt_next.w[1][4] = pmj_pkg::quarter(one_w + as_w);

        wt_next.w[2][0] = '0;
        wt_next.w[2][1] = pmj_pkg::quarter(-one_w + bs_w);
        wt_next.w[2][2] = pmj_pkg::quarter(-one_w - bs_w);
        wt_next.w[2][3] = pmj_pkg::quarter(one_w - bs_w);
        wt_next.w[2][4] = pmj_pkg::quarter(one_w + bs_w);

        wt_next.w[3][0] = one_w[31:0];
        wt_next.w[3][1] = pmj_pkg::quarter(-one_w + ds_w);
        wt_next.w[3][2] = pmj_pkg::quarter(-one_w - ds_w);
        wt_next.w[3][3] = pmj_pkg::quarter(-one_w - ds_w);
        wt_next.w[3][4] = pmj_pkg::quarter(-one_w + ds_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            wt_reg <= wt_next;
    end

    assign wt = wt_reg;

endmodule

// ===== design/pmj_combine.sv =====
// Node store, weight by node products and the rounded, saturated sums.
// Depends on pmj_pkg.
module pmj_combine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pmj_pkg::pmj_ctl_t  ctl,
    input  logic signed [31:0] load_value,
    input  pmj_pkg::pmj_wt_t   wt,
    output logic               out_valid,
    output pmj_pkg::pmj_out_t  out_item
);

    logic signed [pmj_pkg::CW-1:0]     store_reg [pmj_pkg::STORE_DEPTH];
    logic                              load_hit;
    logic [pmj_pkg::STORE_ADDR_W-1:0]  load_addr;

    logic signed [pmj_pkg::PROD_W-1:0]
        prod_reg [pmj_pkg::SET_COUNT][pmj_pkg::AXIS_COUNT][pmj_pkg::NODE_COUNT];
    logic signed [pmj_pkg::ACC_W-1:0]
        part_reg [pmj_pkg::SET_COUNT][pmj_pkg::AXIS_COUNT][pmj_pkg::PART_COUNT];
    logic signed [pmj_pkg::ACC_W-1:0]  tot_w [pmj_pkg::SET_COUNT][pmj_pkg::AXIS_COUNT];
    logic signed [31:0]                res_w [pmj_pkg::SET_COUNT][pmj_pkg::AXIS_COUNT];

    pmj_pkg::pmj_ctl_t ctl5_reg;
    pmj_pkg::pmj_ctl_t ctl6_reg;
    logic              out_valid_reg;
    pmj_pkg::pmj_out_t out_reg;
    pmj_pkg::pmj_out_t out_next;

    assign load_hit  = ctl.valid && (ctl.op == pmj_pkg::OP_LOAD)
                       && (ctl.node_index < pmj_pkg::NODE_COUNT)
                       && (ctl.axis < pmj_pkg::AXIS_COUNT);
    assign load_addr = pmj_pkg::STORE_ADDR_W'(ctl.node_index * pmj_pkg::AXIS_COUNT + ctl.axis);

    // Loads write at the same stage where evaluates read, so order holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pmj_pkg::STORE_DEPTH; k++)
                store_reg[k] <= '0;
        end
        else if (en && load_hit)
        begin
            store_reg[load_addr] <= load_value[pmj_pkg::CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < pmj_pkg::SET_COUNT; s++)
                for (int a = 0; a < pmj_pkg::AXIS_COUNT; a++)
                begin
                    for (int i = 0; i < pmj_pkg::NODE_COUNT; i++)
                        prod_reg[s][a][i] <= $signed(wt.w[s][i])
                                             * store_reg[i * pmj_pkg::AXIS_COUNT + a];
                    part_reg[s][a][0] <= pmj_pkg::ACC_W'(prod_reg[s][a][0])
                                         + pmj_pkg::ACC_W'(prod_reg[s][a][1]);
                    part_reg[s][a][1] <= pmj_pkg::ACC_W'(prod_reg[s][a][2])
                                         + pmj_pkg::ACC_W'(prod_reg[s][a][3]);
                    part_reg[s][a][2] <= pmj_pkg::ACC_W'(prod_reg[s][a][4]);
                end
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        for (int s = 0; s < pmj_pkg::SET_COUNT; s++)
            for (int a = 0; a < pmj_pkg::AXIS_COUNT; a++)
            begin
                // round half up, then scale by 2^-30
                tot_w[s][a] = part_reg[s][a][0] + part_reg[s][a][1] + part_reg[s][a][2]
                              + (pmj_pkg::ACC_W'(1) <<< (pmj_pkg::FRAC_REF - 1));
                res_w[s][a] = pmj_pkg::sat_out(tot_w[s][a] >>> pmj_pkg::FRAC_REF);
            end
        out_next.phys_x = res_w[0][0];
        out_next.phys_y = res_w[0][1];
        out_next.phys_z = res_w[0][2];
        out_next.jac_xx = res_w[1][0];
        out_next.jac_xy = res_w[2][0];
        out_next.jac_xz = res_w[3][0];
        out_next.jac_yx = res_w[1][1];
        out_next.jac_yy = res_w[2][1];
        out_next.jac_yz = res_w[3][1];
        out_next.jac_zx = res_w[1][2];
        out_next.jac_zy = res_w[2][2];
        out_next.jac_zz = res_w[3][2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg      <= '0;
            ctl6_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctl5_reg      <= ctl;
            ctl6_reg      <= ctl5_reg;
            out_valid_reg <= ctl6_reg.valid && (ctl6_reg.op == pmj_pkg::OP_EVAL);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== design/pyramid_map_and_jacobian_unit.sv =====
// Pyramid element mapping and Jacobian. From the accepting edge to rsp_valid an
// item passes two capture stages, the two chained 40-stage divider ranks (one
// quotient bit per stage) with the q saturation stage between them, and the
// weight, product, partial sum and output stages.
// Throughput one item per cycle; a receiver stall holds the whole pipeline.
// Reset (rst_n low, asynchronous) clears all valid bits and the node store.
module pyramid_map_and_jacobian_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pmj_pkg::pmj_in_t  req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pmj_pkg::pmj_out_t rsp_item
);

    // The whole pipeline moves as one; it holds only while a finished
    // result sits in the output register and the receiver stalls.
    logic en;

    // Stage 0: captured item. A load rides in the x slot with its value.
    pmj_pkg::pmj_ctl_t  ctl0_reg;
    logic signed [31:0] x0_reg;
    logic signed [31:0] y0_reg;
    logic signed [31:0] z0_reg;

    // Stage 1: w = 1 - z and the x*y product.
    pmj_pkg::pmj_ctl_t               ctl1_reg;
    logic signed [31:0]              x1_reg;
    logic signed [31:0]              y1_reg;
    logic signed [pmj_pkg::W_W-1:0]  w1_reg;
    logic signed [pmj_pkg::NUM_W-1:0] xy1_reg;

    logic signed [pmj_pkg::NUM_W-1:0] qs_full_w;
    pmj_pkg::pmj_sb1_t               sb1_in_w;
    pmj_pkg::pmj_sb1_t               sb1_reg [pmj_pkg::DIV_LAT];

    logic signed [pmj_pkg::QS_W-1:0] qdiv_w;
    logic signed [pmj_pkg::QS_W-1:0] adiv_w;
    logic signed [pmj_pkg::QS_W-1:0] bdiv_w;
    logic signed [pmj_pkg::QS_W-1:0] d2div_w;

    // Stage 3: top-plane selection and the saturated q for d2.
    pmj_pkg::pmj_sb1_t   sb1_out_w;
    pmj_pkg::pmj_sb2_t   sb2_in_w;
    pmj_pkg::pmj_sb2_t   s3_reg;
    logic signed [31:0]  satq3_reg;
    pmj_pkg::pmj_sb2_t   sb2_reg [pmj_pkg::DIV_LAT];

    // Weight stage side registers.
    pmj_pkg::pmj_ctl_t   ctl4_reg;
    logic signed [31:0]  x4_reg;
    pmj_pkg::pmj_wt_t    wt_w;

    logic                out_valid_w;

    assign en        = !(out_valid_w && rsp_stall);
    assign req_stall = !en;
    assign rsp_valid = out_valid_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
            ctl1_reg <= '0;
        end
        else if (en)
        begin
            ctl0_reg.valid      <= req_valid;
            ctl0_reg.op         <= req_item.op;
            ctl0_reg.node_index <= req_item.node_index;
            ctl0_reg.axis       <= req_item.axis;
            ctl1_reg            <= ctl0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= (req_item.op == pmj_pkg::OP_LOAD) ? req_item.node_value : req_item.ref_x;
            y0_reg  <= req_item.ref_y;
            z0_reg  <= req_item.ref_z;
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            w1_reg  <= (pmj_pkg::W_W'(1) <<< pmj_pkg::FRAC_REF) - pmj_pkg::W_W'(z0_reg);
            xy1_reg <= x0_reg * y0_reg;
        end
    end

    // Top plane value of q: x*y scaled by 2^-30, rounded half up.
    always_comb
    begin
        qs_full_w         = (xy1_reg + (pmj_pkg::NUM_W'(1) <<< (pmj_pkg::FRAC_REF - 1)))
                            >>> pmj_pkg::FRAC_REF;
        sb1_in_w.ctl      = ctl1_reg;
        sb1_in_w.x        = x1_reg;
        sb1_in_w.y        = y1_reg;
        sb1_in_w.w        = w1_reg;
        sb1_in_w.qs       = qs_full_w[pmj_pkg::QS_W-1:0];
        sb1_in_w.wz       = (w1_reg == '0);
    end

    pmj_div u_div_q (
        .clk  (clk),
        .en   (en),
        .num  (xy1_reg),
        .den  (w1_reg),
        .quot (qdiv_w)
    );

    pmj_div u_div_a (
        .clk  (clk),
        .en   (en),
        .num  (pmj_pkg::NUM_W'(y1_reg) <<< pmj_pkg::FRAC_REF),
        .den  (w1_reg),
        .quot (adiv_w)
    );

    pmj_div u_div_b (
        .clk  (clk),
        .en   (en),
        .num  (pmj_pkg::NUM_W'(x1_reg) <<< pmj_pkg::FRAC_REF),
        .den  (w1_reg),
        .quot (bdiv_w)
    );

    // Delay lines that keep item context level with the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pmj_pkg::DIV_LAT; k++)
            begin
                sb1_reg[k] <= '0;
                sb2_reg[k] <= '0;
            end
            s3_reg   <= '0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            sb1_reg[0] <= sb1_in_w;
            sb2_reg[0] <= s3_reg;
            for (int k = 1; k < pmj_pkg::DIV_LAT; k++)
            begin
                sb1_reg[k] <= sb1_reg[k-1];
                sb2_reg[k] <= sb2_reg[k-1];
            end
            s3_reg   <= sb2_in_w;
            ctl4_reg <= sb2_reg[pmj_pkg::DIV_LAT-1].ctl;
        end
    end

    // On the top plane the divided terms drop out: q from the product,
    // a and b straight from y and x.
    always_comb
    begin
        sb1_out_w    = sb1_reg[pmj_pkg::DIV_LAT-1];
        sb2_in_w.ctl = sb1_out_w.ctl;
        sb2_in_w.x   = sb1_out_w.x;
        sb2_in_w.y   = sb1_out_w.y;
        sb2_in_w.w   = sb1_out_w.w;
        sb2_in_w.wz  = sb1_out_w.wz;
        sb2_in_w.q   = sb1_out_w.wz ? sb1_out_w.qs : qdiv_w;
        sb2_in_w.a   = sb1_out_w.wz ? pmj_pkg::QS_W'(sb1_out_w.y) : adiv_w;
        sb2_in_w.b   = sb1_out_w.wz ? pmj_pkg::QS_W'(sb1_out_w.x) : bdiv_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            satq3_reg <= pmj_pkg::sat_q32(sb2_in_w.q);
            x4_reg    <= sb2_reg[pmj_pkg::DIV_LAT-1].x;
        end
    end

    pmj_div u_div_d2 (
        .clk  (clk),
        .en   (en),
        .num  (pmj_pkg::NUM_W'(satq3_reg) <<< pmj_pkg::FRAC_REF),
        .den  (s3_reg.w),
        .quot (d2div_w)
    );

    pmj_weights u_weights (
        .clk     (clk),
        .en      (en),
        .sb      (sb2_reg[pmj_pkg::DIV_LAT-1]),
        .d2_quot (d2div_w),
        .wt      (wt_w)
    );

    pmj_combine u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl        (ctl4_reg),
        .load_value (x4_reg),
        .wt         (wt_w),
        .out_valid  (out_valid_w),
        .out_item   (rsp_item)
    );

endmodule
